>>> rtl/cancrc_pkg.sv
package cancrc_pkg;

  // widths of the frame fields and of the counter store
  localparam int unsigned ID_W       = 11;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned NUM_BYTES  = 8;
  localparam int unsigned BYTE_IDX_W = 3;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned TABLE_SIZE = 32;
  localparam int unsigned TSLOT_W    = 5;
  localparam int unsigned NUM_SLOTS  = TABLE_SIZE + 1;
  localparam int unsigned SLOT_W     = 6;

  localparam logic [CNT_W-1:0]  COUNTER_LAST = CNT_W'(15 - 1);
  localparam logic [BYTE_W-1:0] CRC_POLY     = 8'h1D;
  localparam logic [BYTE_W-1:0] NIBBLE_HI    = 8'hF0;
  localparam logic [ID_W-1:0]   NOCRC_ID     = 11'h202;
  localparam logic [SLOT_W-1:0] NOCRC_SLOT   = SLOT_W'(TABLE_SIZE);

  typedef enum logic [1:0] {
    ACT_PASS = 2'd0,
    ACT_CNT  = 2'd1,
    ACT_CRC  = 2'd2
  } action_t;

  typedef struct packed {
    logic               hit;
    logic [TSLOT_W-1:0] slot;
  } lookup_t;

  localparam logic [ID_W-1:0] ID_TABLE [TABLE_SIZE] = '{
    11'h08F, 11'h0A0, 11'h0A5, 11'h0A6, 11'h0A7, 11'h0B0, 11'h0C2, 11'h0D9,
    11'h0EF, 11'h12F, 11'h145, 11'h163, 11'h173, 11'h197, 11'h199, 11'h19A,
    11'h19F, 11'h1A1, 11'h1AF, 11'h1E1, 11'h1FC, 11'h207, 11'h254, 11'h297,
    11'h2C5, 11'h2E0, 11'h2ED, 11'h302, 11'h30B, 11'h3A7, 11'h3F9, 11'h3FD
  };

  localparam logic [BYTE_W-1:0] SEED_TABLE [TABLE_SIZE] = '{
    8'h75, 8'hBC, 8'h16, 8'hC2, 8'h8E, 8'h4C, 8'hD8, 8'h3E,
    8'h98, 8'h60, 8'h48, 8'hA0, 8'h13, 8'h62, 8'h8F, 8'h17,
    8'hEF, 8'h77, 8'hB5, 8'h78, 8'h66, 8'h51, 8'hB8, 8'hDF,
    8'hFC, 8'h5B, 8'h1D, 8'hC3, 8'hBE, 8'h05, 8'h38, 8'hD7
  };

  // parallel match of the identifier against the constant table
  function automatic lookup_t id_lookup(input logic [ID_W-1:0] id);
    lookup_t res;
    res = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (ID_TABLE[i] == id) begin
        res.hit  = 1'b1;
        res.slot = TSLOT_W'(i);
      end
    end
    return res;
  endfunction

endpackage

>>> rtl/cancrc_in_if.sv
interface cancrc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [cancrc_pkg::ID_W-1:0]           frame_id;
  logic [cancrc_pkg::LEN_W-1:0]          frame_length;
  logic [cancrc_pkg::BYTE_W-1:0]         in_byte_0;
  logic [cancrc_pkg::BYTE_W-1:0]         in_byte_1;
  logic [cancrc_pkg::BYTE_W-1:0]         in_byte_2;
  logic [cancrc_pkg::BYTE_W-1:0]         in_byte_3;
  logic [cancrc_pkg::BYTE_W-1:0]         in_byte_4;
  logic [cancrc_pkg::BYTE_W-1:0]         in_byte_5;
  logic [cancrc_pkg::BYTE_W-1:0]         in_byte_6;
  logic [cancrc_pkg::BYTE_W-1:0]         in_byte_7;

  modport source (
    output valid, frame_id, frame_length, in_byte_0, in_byte_1, in_byte_2,
           in_byte_3, in_byte_4, in_byte_5, in_byte_6, in_byte_7,
    input  ready
  );

  modport sink (
    input  valid, frame_id, frame_length, in_byte_0, in_byte_1, in_byte_2,
           in_byte_3, in_byte_4, in_byte_5, in_byte_6, in_byte_7,
    output ready
  );
endinterface

>>> rtl/cancrc_out_if.sv
interface cancrc_out_if;
  logic                          valid;
  logic                          ready;
  logic [cancrc_pkg::BYTE_W-1:0] out_byte_0;
  logic [cancrc_pkg::BYTE_W-1:0] out_byte_1;
  logic [cancrc_pkg::BYTE_W-1:0] out_byte_2;
  logic [cancrc_pkg::BYTE_W-1:0] out_byte_3;
  logic [cancrc_pkg::BYTE_W-1:0] out_byte_4;
  logic [cancrc_pkg::BYTE_W-1:0] out_byte_5;
  logic [cancrc_pkg::BYTE_W-1:0] out_byte_6;
  logic [cancrc_pkg::BYTE_W-1:0] out_byte_7;
  logic [1:0]                    stamp_action;

  modport source (
    output valid, out_byte_0, out_byte_1, out_byte_2, out_byte_3, out_byte_4,
           out_byte_5, out_byte_6, out_byte_7, stamp_action,
    input  ready
  );

  modport sink (
    input  valid, out_byte_0, out_byte_1, out_byte_2, out_byte_3, out_byte_4,
           out_byte_5, out_byte_6, out_byte_7, stamp_action,
    output ready
  );
endinterface

>>> rtl/cancrc_ram.sv
module cancrc_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/cancrc_crc_unit.sv
module cancrc_crc_unit (
  input  logic [cancrc_pkg::BYTE_W-1:0] crc_in,
  input  logic [cancrc_pkg::BYTE_W-1:0] data_in,
  output logic [cancrc_pkg::BYTE_W-1:0] crc_out
);

  // one byte of crc-8, msb first, eight bit steps
  always_comb begin
    logic [cancrc_pkg::BYTE_W-1:0] c;
    c = crc_in ^ data_in;
    for (int k = 0; k < cancrc_pkg::BYTE_W; k++) begin
      if (c[cancrc_pkg::BYTE_W-1]) begin
        c = {c[cancrc_pkg::BYTE_W-2:0], 1'b0} ^ cancrc_pkg::CRC_POLY;
      end else begin
        c = {c[cancrc_pkg::BYTE_W-2:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

>>> rtl/can_frame_crc_counter_stamp.sv
// Alive-counter and CRC-8 stamper for outgoing CAN frames.
// in_ch (valid/ready) takes one frame: identifier, length and eight data bytes.
// out_ch (valid/ready) gives one result per frame: the eight bytes and
// stamp_action (0 passed unchanged, 1 counter only, 2 counter and CRC).
// Known identifiers and 0x202 get their 4-bit alive counter (0..14) in the
// low nibble of byte 1; known identifiers also get a CRC-8 (poly 0x1D) over
// bytes 1..length-1 in byte 0, started from the identifier's table value.
// Steps: the frame is taken in S_IDLE, the counter store is read at the
// transfer and written back in the next cycle (S_STAMP), then the shared CRC
// byte unit runs one byte per cycle for length-1 bytes in S_CRC, a last S_CRC
// step stores the CRC in byte 0 and S_DONE loads the output register.
// A new frame is taken at the earliest in the cycle after the result is
// loaded, so the block takes no new frame while one is still in work.
// in_ch.ready is high only while the sequencer is idle; a result waiting in
// the output register does not block the next frame, but a finished frame
// waits in the sequencer while the receiver stalls with a result pending.
// Reset (rst_n low, synchronous) clears all alive counters to zero through
// per-entry valid bits, empties the output register and idles the sequencer.
module can_frame_crc_counter_stamp #(
  parameter int unsigned MAX_FRAME_BYTES = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  cancrc_in_if.sink    in_ch,
  cancrc_out_if.source out_ch
);

  localparam logic [cancrc_pkg::LEN_W-1:0] LEN_LIMIT = cancrc_pkg::LEN_W'(MAX_FRAME_BYTES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STAMP,
    S_CRC,
    S_DONE
  } state_t;

  state_t                                state_r;
  logic [cancrc_pkg::BYTE_W-1:0]         bytes_r [cancrc_pkg::NUM_BYTES];
  logic [cancrc_pkg::LEN_W-1:0]          len_r;
  logic [cancrc_pkg::SLOT_W-1:0]         slot_r;
  logic [cancrc_pkg::BYTE_W-1:0]         seed_r;
  cancrc_pkg::action_t                   action_r;
  logic [cancrc_pkg::BYTE_W-1:0]         crc_r;
  logic [cancrc_pkg::LEN_W-1:0]          idx_r;
  logic [cancrc_pkg::NUM_SLOTS-1:0]      cnt_valid_r;
  logic                                  out_valid_r;
  logic [cancrc_pkg::BYTE_W-1:0]         out_bytes_r [cancrc_pkg::NUM_BYTES];
  cancrc_pkg::action_t                   out_action_r;

  logic [cancrc_pkg::BYTE_W-1:0]         in_bytes [cancrc_pkg::NUM_BYTES];
  logic                                  in_xfer;
  cancrc_pkg::lookup_t                   lookup;
  logic [cancrc_pkg::SLOT_W-1:0]         acc_slot;
  logic [cancrc_pkg::BYTE_W-1:0]         acc_seed;
  cancrc_pkg::action_t                   acc_action;
  logic [cancrc_pkg::LEN_W-1:0]          acc_len;
  logic [cancrc_pkg::CNT_W-1:0]          ram_rdata;
  logic [cancrc_pkg::CNT_W-1:0]          cnt_cur;
  logic [cancrc_pkg::CNT_W-1:0]          cnt_nxt;
  logic                                  ram_we;
  logic [cancrc_pkg::BYTE_W-1:0]         crc_nxt;
  logic                                  out_load;

  // input payload gathered into an array
  assign in_bytes[0] = in_ch.in_byte_0;
  assign in_bytes[1] = in_ch.in_byte_1;
  assign in_bytes[2] = in_ch.in_byte_2;
  assign in_bytes[3] = in_ch.in_byte_3;
  assign in_bytes[4] = in_ch.in_byte_4;
  assign in_bytes[5] = in_ch.in_byte_5;
  assign in_bytes[6] = in_ch.in_byte_6;
  assign in_bytes[7] = in_ch.in_byte_7;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // identifier classification at transfer time
  always_comb begin
    lookup   = cancrc_pkg::id_lookup(in_ch.frame_id);
    acc_seed = lookup.hit ? cancrc_pkg::SEED_TABLE[lookup.slot] : '0;
    if (in_ch.frame_id == cancrc_pkg::NOCRC_ID) begin
      acc_slot   = cancrc_pkg::NOCRC_SLOT;
      acc_action = cancrc_pkg::ACT_CNT;
    end else if (acc_seed != '0) begin
      acc_slot   = {1'b0, lookup.slot};
      acc_action = cancrc_pkg::ACT_CRC;
    end else begin
      acc_slot   = {1'b0, lookup.slot};
      acc_action = cancrc_pkg::ACT_PASS;
    end
    acc_len = (in_ch.frame_length > LEN_LIMIT) ? LEN_LIMIT : in_ch.frame_length;
  end

  // alive counter store
  assign cnt_cur = cnt_valid_r[slot_r] ? ram_rdata : '0;
  assign cnt_nxt = (cnt_cur == cancrc_pkg::COUNTER_LAST) ? '0
                                                         : cnt_cur + cancrc_pkg::CNT_W'(1);
  assign ram_we  = (state_r == S_STAMP) && (action_r != cancrc_pkg::ACT_PASS);

  cancrc_ram #(
    .WIDTH (cancrc_pkg::CNT_W),
    .DEPTH (cancrc_pkg::NUM_SLOTS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (cnt_nxt),
    .re    (in_xfer),
    .raddr (acc_slot),
    .rdata (ram_rdata)
  );

  // shared crc byte unit
  cancrc_crc_unit u_crc (
    .crc_in  (crc_r),
    .data_in (bytes_r[idx_r[cancrc_pkg::BYTE_IDX_W-1:0]]),
    .crc_out (crc_nxt)
  );

  // finished frame moves into a free or draining output register
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // sequencer, working registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            bytes_r  <= in_bytes;
            len_r    <= acc_len;
            slot_r   <= acc_slot;
            seed_r   <= acc_seed;
            action_r <= acc_action;
            state_r  <= S_STAMP;
          end
        end
        S_STAMP: begin
          crc_r <= seed_r;
          idx_r <= cancrc_pkg::LEN_W'(1);
          if (action_r == cancrc_pkg::ACT_PASS) begin
            state_r <= S_DONE;
          end else begin
            bytes_r[1]          <= (bytes_r[1] & cancrc_pkg::NIBBLE_HI)
                                   | cancrc_pkg::BYTE_W'(cnt_cur);
            cnt_valid_r[slot_r] <= 1'b1;
            state_r <= (action_r == cancrc_pkg::ACT_CRC) ? S_CRC : S_DONE;
          end
        end
        S_CRC: begin
          if (idx_r < len_r) begin
            crc_r <= crc_nxt;
            idx_r <= idx_r + cancrc_pkg::LEN_W'(1);
          end else begin
            bytes_r[0] <= crc_r;
            state_r    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_bytes_r  <= bytes_r;
            out_action_r <= action_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // result channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte_0   = out_bytes_r[0];
  assign out_ch.out_byte_1   = out_bytes_r[1];
  assign out_ch.out_byte_2   = out_bytes_r[2];
  assign out_ch.out_byte_3   = out_bytes_r[3];
  assign out_ch.out_byte_4   = out_bytes_r[4];
  assign out_ch.out_byte_5   = out_bytes_r[5];
  assign out_ch.out_byte_6   = out_bytes_r[6];
  assign out_ch.out_byte_7   = out_bytes_r[7];
  assign out_ch.stamp_action = out_action_r;

`ifndef SYNTHESIS
  a_accept_to_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_STAMP)
    else $error("frame transfer not followed by stamp step");

  a_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> cnt_nxt <= cancrc_pkg::COUNTER_LAST)
    else $error("alive counter written out of range");

  a_nocrc_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STAMP && action_r == cancrc_pkg::ACT_CNT) |->
      slot_r == cancrc_pkg::NOCRC_SLOT)
    else $error("counter-only frame not on its own slot");

  a_crc_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CRC |-> (idx_r <= len_r || idx_r == cancrc_pkg::LEN_W'(1)))
    else $error("crc byte index past frame length");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ch.ready) |=> state_r == S_DONE)
    else $error("finished frame dropped while output stalled");
`endif

endmodule

>>> tb/cancrc_stamp_checker.sv
module cancrc_stamp_checker #(
  parameter int unsigned MAX_FRAME_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  cancrc_in_if        in_ch,
  cancrc_out_if       out_ch,
  output int unsigned failures,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ALIVE_MOD = 15;

  typedef struct packed {
    cancrc_pkg::action_t                                      action;
    logic [cancrc_pkg::NUM_BYTES-1:0][cancrc_pkg::BYTE_W-1:0] data;
  } stamped_frame_t;

  logic [cancrc_pkg::CNT_W-1:0] alive_count [cancrc_pkg::NUM_SLOTS];
  stamped_frame_t               expected_stamps [$];

  // identifier to counter slot and crc start value
  function automatic void seed_lookup(input logic [cancrc_pkg::ID_W-1:0] id,
                                      output bit hit, output int slot,
                                      output logic [cancrc_pkg::BYTE_W-1:0] seed);
    hit  = 1'b1;
    slot = 0;
    seed = '0;
    case (id)
      11'h08F: begin slot = 0;  seed = 8'h75; end
      11'h0A0: begin slot = 1;  seed = 8'hBC; end
      11'h0A5: begin slot = 2;  seed = 8'h16; end
      11'h0A6: begin slot = 3;  seed = 8'hC2; end
      11'h0A7: begin slot = 4;  seed = 8'h8E; end
      11'h0B0: begin slot = 5;  seed = 8'h4C; end
      11'h0C2: begin slot = 6;  seed = 8'hD8; end
      11'h0D9: begin slot = 7;  seed = 8'h3E; end
      11'h0EF: begin slot = 8;  seed = 8'h98; end
      11'h12F: begin slot = 9;  seed = 8'h60; end
      11'h145: begin slot = 10; seed = 8'h48; end
      11'h163: begin slot = 11; seed = 8'hA0; end
      11'h173: begin slot = 12; seed = 8'h13; end
      11'h197: begin slot = 13; seed = 8'h62; end
      11'h199: begin slot = 14; seed = 8'h8F; end
      11'h19A: begin slot = 15; seed = 8'h17; end
      11'h19F: begin slot = 16; seed = 8'hEF; end
      11'h1A1: begin slot = 17; seed = 8'h77; end
      11'h1AF: begin slot = 18; seed = 8'hB5; end
      11'h1E1: begin slot = 19; seed = 8'h78; end
      11'h1FC: begin slot = 20; seed = 8'h66; end
      11'h207: begin slot = 21; seed = 8'h51; end
      11'h254: begin slot = 22; seed = 8'hB8; end
      11'h297: begin slot = 23; seed = 8'hDF; end
      11'h2C5: begin slot = 24; seed = 8'hFC; end
      11'h2E0: begin slot = 25; seed = 8'h5B; end
      11'h2ED: begin slot = 26; seed = 8'h1D; end
      11'h302: begin slot = 27; seed = 8'hC3; end
      11'h30B: begin slot = 28; seed = 8'hBE; end
      11'h3A7: begin slot = 29; seed = 8'h05; end
      11'h3F9: begin slot = 30; seed = 8'h38; end
      11'h3FD: begin slot = 31; seed = 8'hD7; end
      default: begin
        hit = 1'b0;
      end
    endcase
  endfunction

  // one byte through the crc-8, msb first
  function automatic logic [cancrc_pkg::BYTE_W-1:0] crc8_step(
      input logic [cancrc_pkg::BYTE_W-1:0] crc,
      input logic [cancrc_pkg::BYTE_W-1:0] b);
    logic [cancrc_pkg::BYTE_W-1:0] c;
    int                            k;
    c = crc ^ b;
    for (k = 0; k < 8; k++) begin
      if (c[cancrc_pkg::BYTE_W-1]) begin
        c = (c << 1) ^ cancrc_pkg::CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  // expected output of one frame, advancing the alive counter unless it passes unchanged
  function automatic stamped_frame_t stamp_frame(
      input logic [cancrc_pkg::ID_W-1:0]                        id,
      input logic [cancrc_pkg::LEN_W-1:0]                       len_in,
      input logic [cancrc_pkg::NUM_BYTES-1:0][cancrc_pkg::BYTE_W-1:0] data);
    stamped_frame_t                res;
    bit                            hit;
    int                            slot;
    int                            len;
    int                            i;
    logic [cancrc_pkg::BYTE_W-1:0] seed;
    logic [cancrc_pkg::BYTE_W-1:0] crc;
    logic [cancrc_pkg::CNT_W-1:0]  cnt;
    seed_lookup(id, hit, slot, seed);
    if (!hit) begin
      seed = '0;
    end
    len = (int'(len_in) > int'(MAX_FRAME_BYTES)) ? int'(MAX_FRAME_BYTES) : int'(len_in);
    if (len > cancrc_pkg::NUM_BYTES) begin
      len = cancrc_pkg::NUM_BYTES;
    end
    res.data = data;
    if (id == cancrc_pkg::NOCRC_ID) begin
      slot       = cancrc_pkg::NUM_SLOTS - 1;
      res.action = cancrc_pkg::ACT_CNT;
    end else if (seed != '0) begin
      res.action = cancrc_pkg::ACT_CRC;
    end else begin
      res.action = cancrc_pkg::ACT_PASS;
    end
    if (res.action != cancrc_pkg::ACT_PASS) begin
      cnt               = alive_count[slot];
      res.data[1]       = (data[1] & cancrc_pkg::NIBBLE_HI) | cancrc_pkg::BYTE_W'(cnt);
      alive_count[slot] = cancrc_pkg::CNT_W'((int'(cnt) + 1) % ALIVE_MOD);
      if (res.action == cancrc_pkg::ACT_CRC) begin
        crc = seed;
        for (i = 1; i < len; i++) begin
          crc = crc8_step(crc, res.data[i]);
        end
        res.data[0] = crc;
      end
    end
    return res;
  endfunction

  // predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin
    stamped_frame_t want;
    stamped_frame_t got;
    int             b;
    if (!rst_n) begin
      expected_stamps.delete();
      for (b = 0; b < cancrc_pkg::NUM_SLOTS; b++) begin
        alive_count[b] = '0;
      end
      failures = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_stamps.push_back(stamp_frame(in_ch.frame_id, in_ch.frame_length,
          {in_ch.in_byte_7, in_ch.in_byte_6, in_ch.in_byte_5, in_ch.in_byte_4,
           in_ch.in_byte_3, in_ch.in_byte_2, in_ch.in_byte_1, in_ch.in_byte_0}));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.action = cancrc_pkg::action_t'(out_ch.stamp_action);
        got.data   = {out_ch.out_byte_7, out_ch.out_byte_6, out_ch.out_byte_5,
                      out_ch.out_byte_4, out_ch.out_byte_3, out_ch.out_byte_2,
                      out_ch.out_byte_1, out_ch.out_byte_0};
        if (expected_stamps.size() == 0) begin
          $display("%0t: result with no frame outstanding: bytes %h action %0d",
                   $realtime, got.data, got.action);
          failures++;
        end else begin
          want = expected_stamps.pop_front();
          for (b = 0; b < cancrc_pkg::NUM_BYTES; b++) begin
            if (got.data[b] !== want.data[b]) begin
              $display("%0t: out_byte_%0d expected %02h actual %02h",
                       $realtime, b, want.data[b], got.data[b]);
              failures++;
            end
          end
          if (got.action !== want.action) begin
            $display("%0t: stamp_action expected %0d actual %0d",
                     $realtime, want.action, got.action);
            failures++;
          end
        end
      end
    end
    pending = expected_stamps.size();
  end

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BYTES   = 8;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_FRAMES = 1150;
  localparam int DRAIN_CYCLES  = 30;

  typedef struct packed {
    logic [cancrc_pkg::ID_W-1:0]                              id;
    logic [cancrc_pkg::LEN_W-1:0]                             len;
    logic [cancrc_pkg::NUM_BYTES-1:0][cancrc_pkg::BYTE_W-1:0] data;
  } can_frame_t;

  logic        clk;
  logic        rst_n;
  bit          steady;
  int unsigned failures;
  int unsigned pending;

  cancrc_in_if  in_ch ();
  cancrc_out_if out_ch ();

  can_frame_crc_counter_stamp #(.MAX_FRAME_BYTES(FRAME_BYTES)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cancrc_stamp_checker #(.MAX_FRAME_BYTES(FRAME_BYTES)) u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .failures (failures),
    .pending  (pending)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // put a frame on the input channel and hold it until the transfer
  task automatic drive_frame(input can_frame_t f);
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.frame_id     = f.id;
    in_ch.frame_length = f.len;
    in_ch.in_byte_0    = f.data[0];
    in_ch.in_byte_1    = f.data[1];
    in_ch.in_byte_2    = f.data[2];
    in_ch.in_byte_3    = f.data[3];
    in_ch.in_byte_4    = f.data[4];
    in_ch.in_byte_5    = f.data[5];
    in_ch.in_byte_6    = f.data[6];
    in_ch.in_byte_7    = f.data[7];
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
  endtask

  // drop valid for a number of cycles, with junk on the identifier, length and bytes 0 and 1
  task automatic idle_for(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid        = 1'b0;
      in_ch.frame_id     = cancrc_pkg::ID_W'($urandom);
      in_ch.frame_length = cancrc_pkg::LEN_W'($urandom);
      in_ch.in_byte_0    = cancrc_pkg::BYTE_W'($urandom);
      in_ch.in_byte_1    = cancrc_pkg::BYTE_W'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic logic [cancrc_pkg::NUM_BYTES-1:0][cancrc_pkg::BYTE_W-1:0] random_bytes();
    logic [cancrc_pkg::NUM_BYTES-1:0][cancrc_pkg::BYTE_W-1:0] d;
    int                                                       b;
    for (b = 0; b < cancrc_pkg::NUM_BYTES; b++) begin
      d[b] = cancrc_pkg::BYTE_W'($urandom);
    end
    return d;
  endfunction

  function automatic can_frame_t frame_of(input logic [cancrc_pkg::ID_W-1:0] id,
                                          input logic [cancrc_pkg::LEN_W-1:0] len,
                                          input logic [cancrc_pkg::BYTE_W-1:0] fill);
    can_frame_t f;
    f.id   = id;
    f.len  = len;
    f.data = {cancrc_pkg::NUM_BYTES{fill}};
    return f;
  endfunction

  // mostly table identifiers, some 0x202, near misses and anything else
  function automatic can_frame_t random_frame();
    can_frame_t f;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      f.id = cancrc_pkg::ID_TABLE[$urandom_range(0, cancrc_pkg::TABLE_SIZE - 1)];
    end else if (r < 72) begin
      f.id = cancrc_pkg::NOCRC_ID;
    end else if (r < 80) begin
      f.id = cancrc_pkg::ID_TABLE[$urandom_range(0, cancrc_pkg::TABLE_SIZE - 1)]
             ^ (cancrc_pkg::ID_W'(1) << $urandom_range(0, cancrc_pkg::ID_W - 1));
    end else begin
      f.id = cancrc_pkg::ID_W'($urandom);
    end
    if ($urandom_range(0, 99) < 85) begin
      f.len = cancrc_pkg::LEN_W'($urandom_range(0, 8));
    end else begin
      f.len = cancrc_pkg::LEN_W'($urandom_range(9, 15));
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      f.data = '0;
    end else if (r < 8) begin
      f.data = '1;
    end else begin
      f.data = random_bytes();
    end
    return f;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // receiver back-pressure
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady || $urandom_range(0, 99) < 70) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = 1'b0;
        stall = ($urandom_range(0, 99) < 94) ? $urandom_range(1, 3) : $urandom_range(15, 50);
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    can_frame_t f;
    int         n;
    steady             = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.frame_id     = '0;
    in_ch.frame_length = '0;
    in_ch.in_byte_0    = '0;
    in_ch.in_byte_1    = '0;
    in_ch.in_byte_2    = '0;
    in_ch.in_byte_3    = '0;
    in_ch.in_byte_4    = '0;
    in_ch.in_byte_5    = '0;
    in_ch.in_byte_6    = '0;
    in_ch.in_byte_7    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: byte extremes on the first table entry, random bytes on the last
    drive_frame(frame_of(11'h08F, 4'd8, 8'h00));
    drive_frame(frame_of(11'h08F, 4'd8, 8'hFF));
    idle_for(pick_gap());
    f      = frame_of(11'h3FD, 4'd8, 8'h00);
    f.data = random_bytes();
    drive_frame(f);
    // counter only identifier
    drive_frame(frame_of(cancrc_pkg::NOCRC_ID, 4'd8, 8'hFF));
    drive_frame(frame_of(cancrc_pkg::NOCRC_ID, 4'd0, 8'h5A));
    // pass-through: identifier extremes and an unknown one
    drive_frame(frame_of(11'h000, 4'd8, 8'hA5));
    drive_frame(frame_of(11'h7FF, 4'd8, 8'hFF));
    idle_for(3);
    drive_frame(frame_of(11'h123, 4'd5, 8'h3C));
    // empty and single-byte frames give the start value as crc, then a two-byte frame
    drive_frame(frame_of(11'h197, 4'd0, 8'hFF));
    drive_frame(frame_of(11'h197, 4'd1, 8'hFF));
    drive_frame(frame_of(11'h197, 4'd2, 8'h81));
    // length beyond the frame limit saturates
    drive_frame(frame_of(11'h0A0, 4'd9, 8'h11));
    drive_frame(frame_of(11'h0A0, 4'd15, 8'hFF));
    // bytes past the length must not enter the crc
    f      = frame_of(11'h0A5, 4'd3, 8'h00);
    f.data = random_bytes();
    drive_frame(f);
    f.data[7] = ~f.data[7];
    drive_frame(f);
    // run one counter through several values
    for (n = 0; n < 8; n++) begin
      drive_frame(frame_of(11'h2ED, cancrc_pkg::LEN_W'(n), cancrc_pkg::BYTE_W'(n * 37)));
      idle_for(n % 3);
    end

    // random frames, with stretches of no idling on either side
    for (n = 0; n < RANDOM_FRAMES; n++) begin
      steady = ((n / 120) % 3) == 1;
      drive_frame(random_frame());
      idle_for(pick_gap());
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
    steady      = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> can_frame_crc_counter_stamp.f
rtl/cancrc_pkg.sv
rtl/cancrc_in_if.sv
rtl/cancrc_out_if.sv
rtl/cancrc_ram.sv
rtl/cancrc_crc_unit.sv
rtl/can_frame_crc_counter_stamp.sv
tb/cancrc_stamp_checker.sv
tb/tb.sv
